/* design/mbrpe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbrpe_pkg
// Shared types, codes and helpers of the MBR partition entry decoder.
// ----------------------------------------------------------------------------
package mbrpe_pkg;

  localparam int unsigned GeomW  = 16;
  localparam int unsigned SecW   = 32;
  localparam int unsigned DiskW  = 63;
  localparam int unsigned CylW   = 10;
  localparam int unsigned SnumW  = 6;
  localparam int unsigned HeadW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // Head plus head_count times cylinder never exceeds this width.
  localparam int unsigned TrackW = GeomW + CylW + 1;

  localparam logic [CylW-1:0] CylUnusable = 10'd1023;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SECTORS_PER_TRACK = 2'd0,
    CFG_HEAD_COUNT        = 2'd1,
    CFG_TABLE_BASE        = 2'd2,
    CFG_DISK_SECTORS      = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_EMPTY    = 3'd0,
    KIND_BEYOND   = 3'd1,
    KIND_EXTENDED = 3'd2,
    KIND_FAT12    = 3'd3,
    KIND_FAT16    = 3'd4,
    KIND_FAT32    = 3'd5,
    KIND_OTHER    = 3'd6
  } entry_kind_t;

  localparam logic [7:0] PtExtChs   = 8'h05;
  localparam logic [7:0] PtExtLba   = 8'h0F;
  localparam logic [7:0] PtFat12    = 8'h01;
  localparam logic [7:0] PtFat16Sm  = 8'h04;
  localparam logic [7:0] PtFat16    = 8'h06;
  localparam logic [7:0] PtFat32Chs = 8'h0B;
  localparam logic [7:0] PtFat32Lba = 8'h0C;

  // Load enables of the three converter stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic entry_kind_t classify(input logic [7:0] ptype);
    entry_kind_t k;
    case (ptype) inside
      PtExtChs, PtExtLba:     k = KIND_EXTENDED;
      PtFat12:                k = KIND_FAT12;
      PtFat16Sm, PtFat16:     k = KIND_FAT16;
      PtFat32Chs, PtFat32Lba: k = KIND_FAT32;
      default:                k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* design/mbr_partition_entry_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_partition_entry_decoder_core
// Decodes one MBR partition entry a word into kind, start sector and size.
// ----------------------------------------------------------------------------
// Each entry passes the unpack, multiplier, select and check stages to m_tvalid.
// Throughput: one word per cycle while m_tready is high, else full stages hold.
// The CHS path uses two multiplier stages (head_count, then sectors_per_track).
// Reset clears all stage valid bits and the configuration registers to zero.
module mbr_partition_entry_decoder_core (
  input  wire          clk,
  input  wire          rst,
  // Configuration write channel.
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [62:0]  cfg_data,
  // Entry input.
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [111:0] s_tdata,  // first_secbyte, first_cyllow, first_headnum,
                                 // final_secbyte, final_cyllow, final_headnum,
                                 // lba_first, lba_length
  input  wire  [7:0]   s_tuser,  // part_type
  // Result output.
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [63:0]  m_tdata,  // start_sector, sector_total
  output logic [2:0]   m_tuser   // entry_kind
);

  localparam int unsigned SW = mbrpe_pkg::SecW;

  logic [mbrpe_pkg::GeomW-1:0] sectors_per_track;
  logic [mbrpe_pkg::GeomW-1:0] head_count;
  logic [SW-1:0]               table_base;
  logic [mbrpe_pkg::DiskW-1:0] disk_sectors;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_track <= '0;
      head_count        <= '0;
      table_base        <= '0;
      disk_sectors      <= '0;
    end else if (cfg_valid) begin
      case (mbrpe_pkg::cfg_index_t'(cfg_index))
        mbrpe_pkg::CFG_SECTORS_PER_TRACK: sectors_per_track <= cfg_data[15:0];
        mbrpe_pkg::CFG_HEAD_COUNT:        head_count        <= cfg_data[15:0];
        mbrpe_pkg::CFG_TABLE_BASE:        table_base        <= cfg_data[31:0];
        mbrpe_pkg::CFG_DISK_SECTORS:      disk_sectors      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: a stage loads when it is empty or its successor loads.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5 || m_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  mbrpe_pkg::stage_en_t conv_en;
  assign conv_en = '{s1: en1, s2: en2, s3: en3};

  logic [SW-1:0] chs_start;
  logic [SW-1:0] chs_end;

  mbrpe_chs_conv u_conv_first (
    .clk               (clk),
    .en                (conv_en),
    .secbyte           (s_tdata[7:0]),
    .cyllow            (s_tdata[15:8]),
    .headnum           (s_tdata[23:16]),
    .sectors_per_track (sectors_per_track),
    .head_count        (head_count),
    .lba               (chs_start)
  );

  mbrpe_chs_conv u_conv_final (
    .clk               (clk),
    .en                (conv_en),
    .secbyte           (s_tdata[31:24]),
    .cyllow            (s_tdata[39:32]),
    .headnum           (s_tdata[47:40]),
    .sectors_per_track (sectors_per_track),
    .head_count        (head_count),
    .lba               (chs_end)
  );

  // Side band of the LBA path, carried alongside the converter stages.
  logic [7:0]    type1, type2, type3, type4;
  logic          uselba1, uselba2, uselba3;
  logic [SW-1:0] lstart1, lstart2, lstart3;
  logic [SW-1:0] llen1, llen2, llen3;

  always_ff @(posedge clk) begin
    if (en1) begin
      type1   <= s_tuser;
      uselba1 <= (s_tdata[111:80] != '0);
      lstart1 <= table_base + s_tdata[79:48];
      llen1   <= s_tdata[111:80];
    end
    if (en2) begin
      type2   <= type1;
      uselba2 <= uselba1;
      lstart2 <= lstart1;
      llen2   <= llen1;
    end
    if (en3) begin
      type3   <= type2;
      uselba3 <= uselba2;
      lstart3 <= lstart2;
      llen3   <= llen2;
    end
  end

  // Stage 4: pick the start and size of the entry.
  logic [SW-1:0] start4, size4;

  always_ff @(posedge clk) begin
    if (en4) begin
      type4  <= type3;
      start4 <= uselba3 ? lstart3 : chs_start;
      size4  <= uselba3 ? llen3 : chs_end - chs_start + SW'(1);
    end
  end

  // Stage 5: bound check against the disk size and classification.
  logic [SW:0]   end_excl;
  logic [63:0]   bound;
  logic          beyond;
  mbrpe_pkg::entry_kind_t kind_next;
  logic [SW-1:0] start_next, size_next;

  assign end_excl = {1'b0, start4} + {1'b0, size4};
  assign bound    = {1'b0, disk_sectors} + 64'd1;
  assign beyond   = {{(64-SW-1){1'b0}}, end_excl} > bound;

  always_comb begin
    kind_next  = mbrpe_pkg::classify(type4);
    start_next = start4;
    size_next  = size4;
    if (type4 == 8'd0) begin
      kind_next  = mbrpe_pkg::KIND_EMPTY;
      start_next = '0;
      size_next  = '0;
    end else if (beyond) begin
      kind_next  = mbrpe_pkg::KIND_BEYOND;
      start_next = '0;
      size_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      m_tuser <= kind_next;
      m_tdata <= {size_next, start_next};
    end
  end

  assign m_tvalid = v5;

endmodule
`default_nettype wire

/* design/mbrpe_chs_conv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbrpe_chs_conv
// Three-stage CHS to LBA converter: unpack, track product, sector product.
// ----------------------------------------------------------------------------
module mbrpe_chs_conv (
  input  wire                             clk,
  input  wire mbrpe_pkg::stage_en_t       en,
  input  wire [7:0]                       secbyte,
  input  wire [7:0]                       cyllow,
  input  wire [7:0]                       headnum,
  input  wire [mbrpe_pkg::GeomW-1:0]      sectors_per_track,
  input  wire [mbrpe_pkg::GeomW-1:0]      head_count,
  output logic [mbrpe_pkg::SecW-1:0]      lba
);

  logic [mbrpe_pkg::CylW-1:0]   cyl1;
  logic [mbrpe_pkg::SnumW-1:0]  sec1;
  logic [mbrpe_pkg::HeadW-1:0]  head1;
  logic                         bad1;

  logic [mbrpe_pkg::TrackW-1:0] trk2;
  logic [mbrpe_pkg::SnumW-1:0]  sec2;
  logic                         bad2;

  logic [mbrpe_pkg::TrackW-1:0] trk_next;
  logic [mbrpe_pkg::GeomW+mbrpe_pkg::TrackW-1:0] prod;
  logic [mbrpe_pkg::SecW-1:0]   lba_next;
  logic [mbrpe_pkg::CylW-1:0]   cyl_in;

  assign cyl_in = {secbyte[7:6], cyllow};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      cyl1  <= cyl_in;
      sec1  <= secbyte[5:0];
      head1 <= headnum;
      bad1  <= (cyl_in == mbrpe_pkg::CylUnusable) || (secbyte[5:0] == '0);
    end
  end

  assign trk_next = mbrpe_pkg::TrackW'(head1)
                  + mbrpe_pkg::TrackW'(head_count * cyl1);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      trk2 <= trk_next;
      sec2 <= sec1;
      bad2 <= bad1;
    end
  end

  // All sector arithmetic wraps at 32 bits.
  assign prod = sectors_per_track * trk2;
  assign lba_next = bad2 ? '0
                  : mbrpe_pkg::SecW'(sec2) + prod[mbrpe_pkg::SecW-1:0]
                    - mbrpe_pkg::SecW'(1);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      lba <= lba_next;
    end
  end

endmodule
`default_nettype wire

/* bench/mbr_partition_entry_decoder_core_test.sv */
// ----------------------------------------------------------------------------
// mbr_partition_entry_decoder_core_test
// Self-checking bench for the MBR partition entry decoder. Entry words go in
// through the input stream and result words come back through the output
// stream. Each result is checked against a local decoder model that is fed
// from every accepted input word. The run covers directed corner entries,
// back-pressure and long random runs under several geometry settings.
// ----------------------------------------------------------------------------
module mbr_partition_entry_decoder_core_test;
  import mbrpe_pkg::*;

  typedef struct packed {
    logic [7:0]  part_type;
    logic [7:0]  first_secbyte;
    logic [7:0]  first_cyllow;
    logic [7:0]  first_headnum;
    logic [7:0]  final_secbyte;
    logic [7:0]  final_cyllow;
    logic [7:0]  final_headnum;
    logic [31:0] lba_first;
    logic [31:0] lba_length;
  } entry_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [31:0] start;
    logic [31:0] total;
  } decoded_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [62:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [7:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [2:0]   m_tuser;

  // Local copy of the geometry registers.
  logic [15:0] spt_q = '0;
  logic [15:0] heads_q = '0;
  logic [31:0] base_q = '0;
  logic [62:0] disk_q = '0;

  decoded_t pending_results[$];
  int mismatch_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int stall_req = 0;
  int stall_cnt = 0;

  mbr_partition_entry_decoder_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // A CHS address of cylinder 1023 or sector 0 cannot be converted and maps to 0.
  function automatic logic [31:0] chs_to_sector(logic [7:0] secbyte, logic [7:0] cyl_lo,
                                                logic [7:0] head);
    logic [9:0]  cyl;
    logic [5:0]  snum;
    logic [31:0] track;
    cyl = {secbyte[7:6], cyl_lo};
    snum = secbyte[5:0];
    if (cyl == 10'd1023 || snum == 6'd0) return 32'd0;
    track = 32'(head) + 32'(heads_q) * 32'(cyl);
    return 32'(snum) + 32'(spt_q) * track - 32'd1;
  endfunction

  function automatic decoded_t decode_entry(entry_t e);
    decoded_t    d;
    logic [31:0] first;
    logic [31:0] count;
    logic [63:0] end_excl;
    d = '{KIND_EMPTY, 32'd0, 32'd0};
    if (e.part_type == 8'd0) return d;
    if (e.lba_length == 32'd0) begin
      first = chs_to_sector(e.first_secbyte, e.first_cyllow, e.first_headnum);
      count = chs_to_sector(e.final_secbyte, e.final_cyllow, e.final_headnum) - first + 32'd1;
    end else begin
      first = base_q + e.lba_first;
      count = e.lba_length;
    end
    // The span end is summed in 64 bits, without wrap, before it is compared with the disk.
    end_excl = 64'(first) + 64'(count);
    if (end_excl > 64'(disk_q) + 64'd1) begin
      d.kind = KIND_BEYOND;
      return d;
    end
    case (e.part_type)
      PtExtChs, PtExtLba:     d.kind = KIND_EXTENDED;
      PtFat12:                d.kind = KIND_FAT12;
      PtFat16Sm, PtFat16:     d.kind = KIND_FAT16;
      PtFat32Chs, PtFat32Lba: d.kind = KIND_FAT32;
      default:                d.kind = KIND_OTHER;
    endcase
    d.start = first;
    d.total = count;
    return d;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // Checks result words and records the expectation of each accepted entry word.
  always @(posedge clk) begin
    decoded_t want;
    entry_t   seen;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result word with nothing outstanding", 32'd0, 32'(m_tuser));
        end else begin
          want = pending_results.pop_front();
          if (m_tuser != want.kind) flag_mismatch("entry_kind", 32'(want.kind), 32'(m_tuser));
          if (m_tdata[31:0] != want.start)
            flag_mismatch("start_sector", want.start, m_tdata[31:0]);
          if (m_tdata[63:32] != want.total)
            flag_mismatch("sector_total", want.total, m_tdata[63:32]);
        end
      end
      if (s_tvalid && s_tready) begin
        seen = {s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24],
                s_tdata[39:32], s_tdata[47:40], s_tdata[79:48], s_tdata[111:80]};
        pending_results.push_back(decode_entry(seen));
      end
    end
  end

  // Output ready: random idling, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (stall_req > 0) begin
      stall_cnt = stall_req;
      stall_req = 0;
    end
    if (stall_cnt > 0) begin
      stall_cnt = stall_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_entry(entry_t e);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= e.part_type;
    s_tdata <= {e.lba_length, e.lba_first, e.final_headnum, e.final_cyllow,
                e.final_secbyte, e.first_headnum, e.first_cyllow, e.first_secbyte};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering words and waits until every result word has come back.
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [62:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SECTORS_PER_TRACK: spt_q = value[15:0];
      CFG_HEAD_COUNT:        heads_q = value[15:0];
      CFG_TABLE_BASE:        base_q = value[31:0];
      CFG_DISK_SECTORS:      disk_q = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(logic [15:0] spt, logic [15:0] heads, logic [31:0] base,
                              logic [62:0] disk);
    drain();
    write_reg(CFG_SECTORS_PER_TRACK, 63'(spt));
    write_reg(CFG_HEAD_COUNT, 63'(heads));
    write_reg(CFG_TABLE_BASE, 63'(base));
    write_reg(CFG_DISK_SECTORS, disk);
  endtask

  function automatic entry_t random_entry();
    entry_t   e;
    int       pick;
    logic [7:0] known[7] = '{PtExtChs, PtExtLba, PtFat12, PtFat16Sm, PtFat16,
                             PtFat32Chs, PtFat32Lba};
    e = 120'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 5) e.part_type = 8'd0;
    else if (pick < 50) e.part_type = known[$urandom_range(6)];
    if ($urandom_range(9) == 0) e.first_secbyte[5:0] = 6'd0;
    if ($urandom_range(9) == 0) {e.final_secbyte[7:6], e.final_cyllow} = 10'd1023;
    if ($urandom_range(1) == 0) begin
      e.first_headnum = 8'($urandom_range(15));
      e.final_headnum = 8'($urandom_range(15));
      e.first_cyllow[7:4] = 4'd0;
      e.first_secbyte[7:6] = 2'd0;
    end
    if ($urandom_range(1) == 0) e.lba_first = $urandom_range(65535);
    pick = $urandom_range(99);
    if (pick < 45) e.lba_length = 32'd0;
    else if (pick < 75) e.lba_length = $urandom_range(4096, 1);
    return e;
  endfunction

  task automatic test_reset_state;
    // Registers are zero after reset: a span fits only if start plus size is at most one.
    send_entry('{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_entry('{8'h06, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 32'd0, 32'd0});
    send_entry('{8'h0B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 32'd1});
    send_entry('{8'h0C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 32'd2});
  endtask

  task automatic test_entry_types;
    set_geometry(16'd63, 16'd16, 32'd2048, 63'h10_0000);
    send_entry('{8'h00, 8'h41, 8'h10, 8'h03, 8'hFF, 8'hFF, 8'h0F, 32'd63, 32'd1000});
    send_entry('{PtExtChs, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd63, 32'd1000});
    send_entry('{PtExtLba, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd100, 32'd5});
    send_entry('{PtFat12, 8'h01, 8'h00, 8'h01, 8'h3F, 8'h02, 8'h0F, 32'd0, 32'd0});
    send_entry('{PtFat16Sm, 8'h01, 8'h03, 8'h00, 8'h7F, 8'h20, 8'h0F, 32'd0, 32'd0});
    send_entry('{PtFat16, 8'h05, 8'h00, 8'h02, 8'h3F, 8'h10, 8'h00, 32'd0, 32'd0});
    send_entry('{PtFat32Chs, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd4096, 32'd8192});
    send_entry('{PtFat32Lba, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd1, 32'd1});
    send_entry('{8'h83, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd7, 32'd9});
    send_entry('{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd7, 32'd9});
  endtask

  task automatic test_chs_corners;
    // Start at cylinder 1023, then start and end with sector 0.
    send_entry('{PtFat16, 8'hC1, 8'hFF, 8'h00, 8'h3F, 8'h01, 8'h01, 32'd0, 32'd0});
    send_entry('{PtFat16, 8'hC0, 8'h12, 8'h05, 8'h00, 8'h34, 8'h07, 32'd0, 32'd0});
    // Every bit high but the LBA length: both CHS addresses unusable, size one.
    send_entry('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'd0});
    // Span past the disk, exactly up to its last sector, and one sector more.
    send_entry('{PtFat32Lba, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0, 32'hFFFF_FFFF});
    send_entry('{PtFat32Lba, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0,
                 32'h10_0001 - 32'd2048});
    send_entry('{PtFat32Lba, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0,
                 32'h10_0002 - 32'd2048});
    // Base plus relative start wraps around 32 bits.
    send_entry('{PtFat12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'd16});
    // End address converts to all ones with a start of 0: the span is empty.
    set_geometry(16'hFFFF, 16'h0100, 32'd0, 63'd0);
    send_entry('{PtFat32Lba, 8'h00, 8'h00, 8'h00, 8'h41, 8'h00, 8'h01, 32'd0, 32'd0});
    // Zero geometry is used as is in the conversion.
    set_geometry(16'd0, 16'd0, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    send_entry('{PtFat16, 8'h02, 8'h10, 8'h04, 8'hBF, 8'hFE, 8'hFF, 32'd0, 32'd0});
    send_entry('{PtFat16, 8'h3F, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 32'd0, 32'd0});
  endtask

  task automatic test_backpressure;
    set_geometry(16'd63, 16'd255, 32'd63, 63'hFFFF_FFFF);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_entry(random_entry());
    stall_req = 300;
    repeat (99) send_entry(random_entry());
    // The sender pauses here until every result word has come back.
    drain();
  endtask

  task automatic test_random_entries;
    logic [63:0] wide;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 61 : 0;
      sink_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 7 : 0;
      for (int g = 0; g < 4; g++) begin
        wide = {$urandom, $urandom};
        case (g)
          0: set_geometry(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
          1: set_geometry(16'd0, 16'd0, 32'd0, 63'd0);
          2: set_geometry(16'($urandom_range(255, 1)), 16'($urandom_range(255, 1)),
                          $urandom_range(65535), wide[62:0] >> $urandom_range(40, 20));
          default: set_geometry(16'($urandom), 16'($urandom), $urandom,
                                wide[62:0] >> $urandom_range(62));
        endcase
        repeat (145) send_entry(random_entry());
      end
    end
    src_idle_pct = 0;
    sink_idle_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_entry_types();
    test_chs_corners();
    test_backpressure();
    test_random_entries();
    drain();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mbrpe_pkg.sv
design/mbrpe_chs_conv.sv
design/mbr_partition_entry_decoder_core.sv
bench/mbr_partition_entry_decoder_core_test.sv
